>>> sv/dgp_pkg.sv
`default_nettype none

package dgp_pkg;

  localparam int CoordBits    = 12;
  localparam int GlyphColumns = 5;
  localparam int GlyphRows    = 7;
  localparam int MaskW        = GlyphColumns * GlyphRows;
  localparam int RadiusW      = 4;
  localparam int FactorW      = 5;
  localparam int ProdW        = FactorW + RadiusW;
  localparam int SumW         = ((CoordBits > ProdW) ? CoordBits : ProdW) + 1;
  localparam int StartW       = 12;
  localparam int StartExtW    = (CoordBits > StartW) ? CoordBits : StartW;
  localparam int ColW         = $clog2(GlyphColumns);
  localparam int RowW         = $clog2(GlyphRows);

  localparam logic [7:0] CodeZero  = 8'd48;
  localparam logic [7:0] CodeNine  = 8'd57;
  localparam logic [7:0] CodeOne   = 8'd49;
  localparam logic [7:0] CodeColon = 8'd58;
  localparam logic [7:0] CodeDot   = 8'd46;
  localparam logic [7:0] CodeDash  = 8'd45;

  localparam logic [RadiusW-1:0] RadiusReset = RadiusW'(1);

  typedef logic [CoordBits-1:0] coord_t;

  // Column bytes of the digit glyphs; row r of a column is lit by bit r+1.
  function automatic logic [7:0] glyph_byte(input logic [3:0] digit,
                                            input logic [2:0] col);
    logic [39:0] row_bytes;
    begin
      unique case (digit)
        4'd0:    row_bytes = 40'h7C_82_82_82_7C;
        4'd1:    row_bytes = 40'h00_00_00_02_FE;
        4'd2:    row_bytes = 40'hE4_92_92_92_4C;
        4'd3:    row_bytes = 40'h44_92_92_92_6C;
        4'd4:    row_bytes = 40'h1E_10_10_10_FE;
        4'd5:    row_bytes = 40'h5E_92_92_92_62;
        4'd6:    row_bytes = 40'h7C_92_92_92_64;
        4'd7:    row_bytes = 40'h02_E2_12_0A_06;
        4'd8:    row_bytes = 40'h6C_92_92_92_6C;
        4'd9:    row_bytes = 40'h4C_92_92_92_7C;
        default: row_bytes = 40'h0;
      endcase
      glyph_byte = row_bytes[8*(4 - 32'(col)) +: 8];
    end
  endfunction

  // Column-major dot mask of one digit, one bit for each glyph position.
  function automatic logic [MaskW-1:0] glyph_mask(input logic [3:0] digit);
    logic [MaskW-1:0] mask;
    logic [7:0]       col_byte;
    begin
      mask = '0;
      for (int c = 0; c < GlyphColumns; c++) begin
        col_byte = glyph_byte(digit, 3'(c));
        for (int r = 0; r < GlyphRows; r++) begin
          mask[c*GlyphRows + r] = col_byte[r + 1];
        end
      end
      glyph_mask = mask;
    end
  endfunction

  function automatic coord_t sat_start(input logic [StartW-1:0] start_x);
    logic [StartExtW-1:0] ext;
    begin
      ext = StartExtW'(start_x);
      if (ext > StartExtW'({CoordBits{1'b1}})) begin
        sat_start = {CoordBits{1'b1}};
      end else begin
        sat_start = CoordBits'(ext);
      end
    end
  endfunction

endpackage

`default_nettype wire

>>> sv/dgp_coord_unit.sv
`default_nettype none

module dgp_coord_unit (
  input  wire dgp_pkg::coord_t                  base_i,
  input  wire logic [dgp_pkg::FactorW-1:0]      factor_i,
  input  wire logic [dgp_pkg::RadiusW-1:0]      radius_i,
  output dgp_pkg::coord_t                       coord_o
);

  logic [dgp_pkg::ProdW-1:0] prod;
  logic [dgp_pkg::SumW-1:0]  sum;

  assign prod = dgp_pkg::ProdW'(factor_i) * dgp_pkg::ProdW'(radius_i);
  assign sum  = dgp_pkg::SumW'(base_i) + dgp_pkg::SumW'(prod);

  always_comb begin
    if (sum > dgp_pkg::SumW'({dgp_pkg::CoordBits{1'b1}})) begin
      coord_o = {dgp_pkg::CoordBits{1'b1}};
    end else begin
      coord_o = dgp_pkg::CoordBits'(sum);
    end
  end

endmodule

`default_nettype wire

>>> sv/dot_glyph_placer_top.sv
// Dot glyph placer. Each input transfer carries one character code, the code
// that follows it, the string origin and a flag that reloads the cursor from
// start_x. The block answers with one output transfer per dot centre, with
// last set on the final dot of the character; characters without dots give
// no output transfer and only move the cursor.
// A digit has 35 glyph positions. The scan runs up to the last lit position,
// one position per cycle unless a lit position waits for the receiver, through
// one coordinate unit (multiply by radius, add, saturate) for each axis; the x
// unit also advances the cursor in the final advance state. When the receiver
// keeps up, each dot is registered into the output register as its glyph position
// is scanned. The block is not ready for input while the character is scanned and
// the cursor advanced, so a new character is taken only once the previous is done.
// The dot radius is written through the configuration channel, which is
// always ready, and must only be written while the block is idle.
// Reset clears the cursor to zero, sets the radius to one and empties the
// output register. When the receiver stalls, the pending dot is held in the
// output register and the scan waits at the next lit position.
`default_nettype none

module dot_glyph_placer_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [dgp_pkg::RadiusW-1:0]       cfg_data_i,
  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire logic                              first_i,
  input  wire logic [dgp_pkg::StartW-1:0]        start_x_i,
  input  wire dgp_pkg::coord_t                   origin_y_i,
  input  wire logic [7:0]                        char_code_i,
  input  wire logic [7:0]                        next_code_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      dgp_pkg::coord_t                   dot_x_o,
  output      dgp_pkg::coord_t                   dot_y_o,
  output      logic                              last_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StAdv  = 3'b100
  } state_e;

  typedef enum logic [4:0] {
    KindDigit = 5'b00001,
    KindColon = 5'b00010,
    KindDot   = 5'b00100,
    KindDash  = 5'b01000,
    KindNone  = 5'b10000
  } kind_e;

  state_e                         state_q, state_d;
  kind_e                          kind_q, kind_in;
  logic [dgp_pkg::RadiusW-1:0]    radius_q;
  dgp_pkg::coord_t                cursor_q, cursor_d;
  dgp_pkg::coord_t                origin_y_q;
  logic [dgp_pkg::MaskW-1:0]      mask_q, mask_in;
  logic [dgp_pkg::ColW-1:0]       col_q;
  logic [dgp_pkg::RowW-1:0]       row_q;
  logic [dgp_pkg::FactorW-1:0]    adv_q, adv_in;
  logic [dgp_pkg::FactorW-1:0]    kx, ky, x_factor;
  dgp_pkg::coord_t                x_coord, y_coord;
  logic                           out_valid_q;
  dgp_pkg::coord_t                dot_x_q, dot_y_q;
  logic                           last_q;
  logic                           in_fire, out_free, step, emit, last_d;
  logic [3:0]                     digit_in;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign emit        = (state_q == StScan) && mask_q[0] && out_free;
  assign step        = (state_q == StScan) && (!mask_q[0] || out_free);
  assign last_d      = (mask_q[dgp_pkg::MaskW-1:1] == '0);
  assign digit_in    = 4'(char_code_i - dgp_pkg::CodeZero);

  always_comb begin
    if (char_code_i >= dgp_pkg::CodeZero && char_code_i <= dgp_pkg::CodeNine) begin
      kind_in = KindDigit;
    end else if (char_code_i == dgp_pkg::CodeColon) begin
      kind_in = KindColon;
    end else if (char_code_i == dgp_pkg::CodeDot) begin
      kind_in = KindDot;
    end else if (char_code_i == dgp_pkg::CodeDash) begin
      kind_in = KindDash;
    end else begin
      kind_in = KindNone;
    end
  end

  always_comb begin
    unique case (kind_in)
      KindDigit: begin
        mask_in = dgp_pkg::glyph_mask(digit_in);
        adv_in  = (next_code_i == dgp_pkg::CodeOne) ? 5'd10 : 5'd20;
      end
      KindColon: begin
        mask_in = dgp_pkg::MaskW'(2'b11);
        adv_in  = 5'd8;
      end
      KindDot: begin
        mask_in = dgp_pkg::MaskW'(1'b1);
        adv_in  = 5'd8;
      end
      KindDash: begin
        mask_in = dgp_pkg::MaskW'(2'b11);
        adv_in  = 5'd20;
      end
      default: begin
        mask_in = '0;
        adv_in  = 5'd20;
      end
    endcase
  end

  always_comb begin
    unique case (kind_q)
      KindDigit: begin
        kx = dgp_pkg::FactorW'(col_q) * 5'd3;
        ky = dgp_pkg::FactorW'(row_q) * 5'd3;
      end
      KindColon: begin
        kx = 5'd0;
        ky = (row_q == '0) ? 5'd15 : 5'd4;
      end
      KindDot: begin
        kx = 5'd0;
        ky = 5'd18;
      end
      KindDash: begin
        kx = (row_q == '0) ? 5'd9 : 5'd12;
        ky = 5'd8;
      end
      default: begin
        kx = 5'd0;
        ky = 5'd0;
      end
    endcase
  end

  assign x_factor = (state_q == StAdv) ? adv_q : kx;

  dgp_coord_unit u_x_unit (
    .base_i   (cursor_q),
    .factor_i (x_factor),
    .radius_i (radius_q),
    .coord_o  (x_coord)
  );

  dgp_coord_unit u_y_unit (
    .base_i   (origin_y_q),
    .factor_i (ky),
    .radius_i (radius_q),
    .coord_o  (y_coord)
  );

  always_comb begin
    state_d  = state_q;
    cursor_d = cursor_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StScan;
          if (first_i) begin
            cursor_d = dgp_pkg::sat_start(start_x_i);
          end
        end
      end
      StScan: begin
        if (mask_q == '0) begin
          state_d = StAdv;
        end
      end
      StAdv: begin
        state_d  = StIdle;
        cursor_d = x_coord;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cursor_q    <= '0;
      radius_q    <= dgp_pkg::RadiusReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      if (cfg_valid_i && cfg_ready_o) begin
        radius_q <= cfg_data_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q     <= kind_in;
      mask_q     <= mask_in;
      adv_q      <= adv_in;
      origin_y_q <= origin_y_i;
      col_q      <= '0;
      row_q      <= '0;
    end else if (step) begin
      mask_q <= mask_q >> 1;
      if (row_q == dgp_pkg::RowW'(dgp_pkg::GlyphRows - 1)) begin
        row_q <= '0;
        col_q <= col_q + 1'b1;
      end else begin
        row_q <= row_q + 1'b1;
      end
    end
    if (emit) begin
      dot_x_q <= x_coord;
      dot_y_q <= y_coord;
      last_q  <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dot_x_o     = dot_x_q;
  assign dot_y_o     = dot_y_q;
  assign last_o      = last_q;

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == StScan))
    else $error("accepted character did not start a scan");

  a_adv_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StAdv) |=> (state_q == StIdle))
    else $error("cursor advance did not return to idle");

  a_cursor_held_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |=> $stable(cursor_q))
    else $error("cursor moved during a scan");

  a_last_empties_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_d) |=> (mask_q == '0) && out_valid_q && last_q)
    else $error("final dot left lit positions behind");

endmodule

`default_nettype wire

>>> tb/tb_dot_glyph_placer_top.sv
`default_nettype none

module tb_dot_glyph_placer_top;

  localparam int MaxDots       = dgp_pkg::GlyphColumns * dgp_pkg::GlyphRows;
  localparam int CoordMax      = (1 << dgp_pkg::CoordBits) - 1;
  localparam int SettleCycles  = 50;
  localparam int WatchdogLimit = 5000;
  localparam int RandomItems   = 400;
  localparam int HoldCycles    = 200;

  localparam logic [7:0] GlyphRom [10][dgp_pkg::GlyphColumns] = '{
    '{8'h7C, 8'h82, 8'h82, 8'h82, 8'h7C},
    '{8'h00, 8'h00, 8'h00, 8'h02, 8'hFE},
    '{8'hE4, 8'h92, 8'h92, 8'h92, 8'h4C},
    '{8'h44, 8'h92, 8'h92, 8'h92, 8'h6C},
    '{8'h1E, 8'h10, 8'h10, 8'h10, 8'hFE},
    '{8'h5E, 8'h92, 8'h92, 8'h92, 8'h62},
    '{8'h7C, 8'h92, 8'h92, 8'h92, 8'h64},
    '{8'h02, 8'hE2, 8'h12, 8'h0A, 8'h06},
    '{8'h6C, 8'h92, 8'h92, 8'h92, 8'h6C},
    '{8'h4C, 8'h92, 8'h92, 8'h92, 8'h7C}
  };

  typedef struct packed {
    dgp_pkg::coord_t dot_x;
    dgp_pkg::coord_t dot_y;
    logic            last;
  } dot_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [dgp_pkg::RadiusW-1:0]  cfg_data_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic                         first_i;
  logic [dgp_pkg::StartW-1:0]   start_x_i;
  dgp_pkg::coord_t              origin_y_i;
  logic [7:0]                   char_code_i;
  logic [7:0]                   next_code_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  dgp_pkg::coord_t              dot_x_o;
  dgp_pkg::coord_t              dot_y_o;
  logic                         last_o;

  dot_t                         pending_dots[$];
  dgp_pkg::coord_t              cursor_q;
  logic [dgp_pkg::RadiusW-1:0]  radius_q;
  int                           mismatches;
  int                           idle_cycles;
  int                           items_sent;
  int                           hold_cycles;
  bit                           tx_idle;
  bit                           rx_idle;

  dot_glyph_placer_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .first_i     (first_i),
    .start_x_i   (start_x_i),
    .origin_y_i  (origin_y_i),
    .char_code_i (char_code_i),
    .next_code_i (next_code_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dot_x_o     (dot_x_o),
    .dot_y_o     (dot_y_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic dgp_pkg::coord_t clip(input int unsigned v);
    return (v > CoordMax) ? dgp_pkg::coord_t'(CoordMax) : dgp_pkg::coord_t'(v);
  endfunction

  // Works out the dot centres of one character and moves the cursor on.
  function automatic void place_char(input bit first,
                                     input logic [dgp_pkg::StartW-1:0] sx,
                                     input dgp_pkg::coord_t oy, input logic [7:0] code,
                                     input logic [7:0] nxt);
    int unsigned     c;
    int unsigned     r;
    int unsigned     adv;
    int unsigned     n;
    logic [7:0]      col_bits;
    dgp_pkg::coord_t xs [MaxDots];
    dgp_pkg::coord_t ys [MaxDots];
    r = radius_q;
    n = 0;
    if (first) begin
      cursor_q = clip(sx);
    end
    c = cursor_q;
    if (code >= dgp_pkg::CodeZero && code <= dgp_pkg::CodeNine) begin
      for (int col = 0; col < dgp_pkg::GlyphColumns; col++) begin
        col_bits = GlyphRom[code - dgp_pkg::CodeZero][col];
        for (int row = 0; row < dgp_pkg::GlyphRows; row++) begin
          if (col_bits[row + 1]) begin
            xs[n] = clip(c + 3 * r * col);
            ys[n] = clip(oy + 3 * r * row);
            n++;
          end
        end
      end
      adv = (nxt == dgp_pkg::CodeOne) ? 10 * r : 20 * r;
    end else if (code == dgp_pkg::CodeColon) begin
      xs[0] = clip(c);
      ys[0] = clip(oy + 15 * r);
      xs[1] = clip(c);
      ys[1] = clip(oy + 4 * r);
      n = 2;
      adv = 8 * r;
    end else if (code == dgp_pkg::CodeDot) begin
      xs[0] = clip(c);
      ys[0] = clip(oy + 18 * r);
      n = 1;
      adv = 8 * r;
    end else if (code == dgp_pkg::CodeDash) begin
      xs[0] = clip(c + 9 * r);
      ys[0] = clip(oy + 8 * r);
      xs[1] = clip(c + 12 * r);
      ys[1] = clip(oy + 8 * r);
      n = 2;
      adv = 20 * r;
    end else begin
      adv = 20 * r;
    end
    for (int i = 0; i < n; i++) begin
      pending_dots.push_back('{dot_x: xs[i], dot_y: ys[i], last: (i == n - 1)});
    end
    cursor_q = clip(c + adv);
  endfunction

  function automatic void log_mismatch(input string detail);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $time, detail);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("dot_glyph_placer_top verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_dots.size() == 0) begin
          log_mismatch($sformatf("unexpected dot x=%0d y=%0d last=%0b",
                                 dot_x_o, dot_y_o, last_o));
        end else begin
          dot_t want;
          want = pending_dots.pop_front();
          if (dot_x_o !== want.dot_x) begin
            log_mismatch($sformatf("dot_x expected %0d got %0d", want.dot_x, dot_x_o));
          end
          if (dot_y_o !== want.dot_y) begin
            log_mismatch($sformatf("dot_y expected %0d got %0d", want.dot_y, dot_y_o));
          end
          if (last_o !== want.last) begin
            log_mismatch($sformatf("last expected %0b got %0b", want.last, last_o));
          end
        end
      end
    end
  end

  // The receiver stalls at random before each transfer in its idle phases or, on request, holds off
  // for a long stretch.
  initial begin : receiver
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 18) : 0;
        if (stall != 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i) && hold_cycles == 0);
    end
  end

  task automatic send_char(input bit first, input logic [dgp_pkg::StartW-1:0] sx,
                           input dgp_pkg::coord_t oy,
                           input logic [7:0] code, input logic [7:0] nxt);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 18) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    first_i     <= first;
    start_x_i   <= sx;
    origin_y_i  <= oy;
    char_code_i <= code;
    next_code_i <= nxt;
    do @(posedge clk_i); while (!in_ready_o);
    place_char(first, sx, oy, code, nxt);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_dots.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_radius(input logic [dgp_pkg::RadiusW-1:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    radius_q = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] random_code();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return dgp_pkg::CodeZero + 8'($urandom_range(0, 9));
    if (pick < 78) return dgp_pkg::CodeColon;
    if (pick < 86) return dgp_pkg::CodeDot;
    if (pick < 94) return dgp_pkg::CodeDash;
    return 8'($urandom_range(0, 255));
  endfunction

  // A string of characters whose next codes mostly follow the string, with some noise.
  task automatic send_random_string();
    logic [7:0]                 codes [12];
    int unsigned                len;
    dgp_pkg::coord_t            oy;
    logic [7:0]                 nxt;
    logic [dgp_pkg::StartW-1:0] sx;
    bit                         first;
    len = $urandom_range(1, 12);
    oy  = dgp_pkg::coord_t'($urandom_range(0, 4095));
    for (int i = 0; i < len; i++) begin
      codes[i] = random_code();
    end
    for (int i = 0; i < len; i++) begin
      first = (i == 0) || ($urandom_range(0, 19) == 0);
      nxt = (i + 1 < len) ? codes[i + 1] : 8'd0;
      if ($urandom_range(0, 9) == 0) begin
        nxt = 8'($urandom_range(0, 255));
      end
      sx = $urandom_range(0, 1) ? dgp_pkg::StartW'($urandom_range(0, 4095))
                                : dgp_pkg::StartW'($urandom_range(0, 1023));
      send_char(first, sx, oy, codes[i], nxt);
      items_sent++;
    end
  endtask

  task automatic test_reset_state();
    send_char(1'b0, 12'd0, 12'd0, dgp_pkg::CodeZero + 8'd8, dgp_pkg::CodeOne);
    send_char(1'b0, 12'd0, 12'd20, dgp_pkg::CodeOne, dgp_pkg::CodeDot);
  endtask

  task automatic test_digits();
    send_char(1'b1, 12'd5, 12'd3, dgp_pkg::CodeZero, dgp_pkg::CodeOne);
    for (int d = 1; d < 10; d++) begin
      send_char(1'b0, 12'd0, 12'd3, dgp_pkg::CodeZero + 8'(d),
                (d % 2 == 1) ? dgp_pkg::CodeOne : dgp_pkg::CodeZero);
    end
  endtask

  task automatic test_punctuation();
    send_char(1'b1, 12'd100, 12'd50, dgp_pkg::CodeColon, dgp_pkg::CodeZero);
    send_char(1'b0, 12'd0, 12'd50, dgp_pkg::CodeDot, dgp_pkg::CodeDash);
    send_char(1'b0, 12'd0, 12'd50, dgp_pkg::CodeDash, 8'd0);
    send_char(1'b0, 12'd0, 12'd50, 8'd0, dgp_pkg::CodeOne);
    send_char(1'b0, 12'd0, 12'd50, 8'd255, 8'd255);
    send_char(1'b0, 12'd0, 12'd50, 8'd128, dgp_pkg::CodeOne);
    send_char(1'b0, 12'd0, 12'd50, 8'd65, dgp_pkg::CodeColon);
  endtask

  task automatic test_saturation();
    write_radius(4'd15);
    send_char(1'b1, 12'd4095, 12'd4095, dgp_pkg::CodeZero + 8'd8, 8'd255);
    send_char(1'b1, 12'd3900, 12'd3950, dgp_pkg::CodeDash, dgp_pkg::CodeOne);
    send_char(1'b1, 12'd3800, 12'd3700, dgp_pkg::CodeZero, dgp_pkg::CodeOne);
    send_char(1'b0, 12'd4095, 12'd0, dgp_pkg::CodeColon, dgp_pkg::CodeDot);
  endtask

  task automatic test_zero_radius();
    write_radius(4'd0);
    send_char(1'b1, 12'd1234, 12'd2345, dgp_pkg::CodeZero + 8'd8, dgp_pkg::CodeOne);
    send_char(1'b0, 12'd0, 12'd2345, dgp_pkg::CodeColon, dgp_pkg::CodeDash);
    send_char(1'b0, 12'd0, 12'd2345, dgp_pkg::CodeDash, 8'd0);
  endtask

  task automatic test_backpressure();
    write_radius(4'd3);
    tx_idle = 1'b0;
    hold_cycles = HoldCycles;
    for (int i = 0; i < 8; i++) begin
      send_char(i == 0, 12'd40, 12'd60, dgp_pkg::CodeZero + 8'(i),
                dgp_pkg::CodeZero + 8'(i + 1));
    end
    wait_drained();
  endtask

  task automatic test_random();
    int          phase;
    int          phase_end;
    logic [3:0]  r;
    phase = 0;
    items_sent = 0;
    while (items_sent < RandomItems) begin
      case (phase % 5)
        0:       r = 4'd1;
        1:       r = 4'd15;
        default: r = 4'($urandom_range(0, 15));
      endcase
      write_radius(r);
      tx_idle = phase[0];
      rx_idle = phase[1];
      phase_end = items_sent + 50;
      while (items_sent < phase_end) begin
        send_random_string();
      end
      phase++;
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    first_i     = 1'b0;
    start_x_i   = '0;
    origin_y_i  = '0;
    char_code_i = '0;
    next_code_i = '0;
    cursor_q    = '0;
    radius_q    = dgp_pkg::RadiusReset;
    mismatches  = 0;
    idle_cycles = 0;
    items_sent  = 0;
    hold_cycles = 0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_digits();
    test_punctuation();
    test_saturation();
    test_zero_radius();
    test_backpressure();
    test_random();

    wait_drained();
    if (pending_dots.size() != 0) begin
      log_mismatch($sformatf("%0d dots never arrived", pending_dots.size()));
    end
    if (mismatches == 0) begin
      $display("dot_glyph_placer_top verification clean");
    end else begin
      $display("dot_glyph_placer_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
sv/dgp_pkg.sv
sv/dgp_coord_unit.sv
sv/dot_glyph_placer_top.sv
tb/tb_dot_glyph_placer_top.sv
